// ----- design/dfs_pkg.sv -----
// Shared constants, codes and types of the dataflow firing scheduler.
// No dependencies; the channel interfaces and the scheduler import this package.
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

    // default sizes of the instance and slot stores
    localparam int DEF_INSTANCES    = 16;
    localparam int DEF_PREDECESSORS = 8;
    localparam int DEF_TOKEN_BITS   = 8;

    // fixed field widths
    localparam int CMD_W      = 2;
    localparam int INST_W     = 4;
    localparam int PRED_W     = 3;
    localparam int FIRE_W     = 16;
    localparam int EV_W       = 2;
    localparam int COMP_W     = 32;
    localparam int RUN_W      = 4;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // most results one request may cause, and the counter for starts
    localparam int MAX_RESULTS = 16;
    localparam int STARTS_W    = $clog2(MAX_RESULTS);

    // request commands
    localparam logic [CMD_W-1:0] CMD_TOKEN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DONE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd2;

    // event codes
    localparam logic [EV_W-1:0] EV_REQUEST = 2'd0;
    localparam logic [EV_W-1:0] EV_START   = 2'd1;
    localparam logic [EV_W-1:0] EV_DONE    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PARALLELISM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRED_MASK   = 2'd1;

    // per-instance state row
    typedef struct packed {
        logic [FIRE_W-1:0] queued;
        logic [RUN_W-1:0]  running;
        logic [COMP_W-1:0] completed;
    } inst_row_t;

    localparam int INST_ROW_W = $bits(inst_row_t);

    // scheduler sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- design/dfs_ifs.sv -----
// Channel interfaces of the dataflow firing scheduler: config, request, event.
// Depends on dfs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dfs_cfg_if;
    import dfs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface dfs_req_if;
    import dfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [INST_W-1:0] instance_req;
    logic [PRED_W-1:0] predecessor;
    logic [FIRE_W-1:0] firing_count;

    modport source (output valid, output command, output instance_req,
                    output predecessor, output firing_count, input ready);
    modport sink   (input valid, input command, input instance_req,
                    input predecessor, input firing_count, output ready);
endinterface

interface dfs_evt_if;
    import dfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [EV_W-1:0]   event_res;
    logic [INST_W-1:0] event_instance;
    logic [COMP_W-1:0] completed_total;
    logic [FIRE_W-1:0] queued_left;
    logic              last;

    modport source (output valid, output event_res, output event_instance,
                    output completed_total, output queued_left, output last,
                    input ready);
    modport sink   (input valid, input event_res, input event_instance,
                    input completed_total, input queued_left, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- design/dfs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/dataflow_firing_scheduler.sv -----
// Dataflow firing scheduler: token counting, firing queue and execution starts.
// Depends on dfs_pkg, the channel interfaces in dfs_ifs and the dfs_ram memory.
//
// Usage:
//   cfg : register writes (index 0 parallelism degree, 1 predecessor mask),
//         always ready; write only while the block is idle.
//   req : one request at a time (token, completion or enqueue) for an instance.
//   evt : result events, each with the instance, its completion total and the
//         firings still queued; last marks the final event of a request.
// Sequence: a request is taken, its instance row and token row are read from
//   the two state memories in the next cycle and modified; then one event
//   leaves per cycle through the output register while evt takes them. A
//   request causes 1 to 16 events, or none.
// Reset: all counters read as zero (per-row valid bits, no clearing pass),
//   parallelism degree 1, no predecessor connected.
// Stall: while evt is not taken the output register holds its event and the
//   next event waits; a new request is taken as soon as the last event of the
//   previous one sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module dataflow_firing_scheduler
    import dfs_pkg::*;
#(
    parameter int INSTANCES    = DEF_INSTANCES,
    parameter int PREDECESSORS = DEF_PREDECESSORS,
    parameter int TOKEN_BITS   = DEF_TOKEN_BITS
)(
    input  logic      clk,
    input  logic      rst_n,
    dfs_cfg_if.sink   cfg,
    dfs_req_if.sink   req,
    dfs_evt_if.source evt
);

    localparam int IW        = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
    localparam int PW        = (PREDECESSORS > 1) ? $clog2(PREDECESSORS) : 1;
    localparam int TOK_ROW_W = PREDECESSORS * TOKEN_BITS;

    typedef logic [PREDECESSORS-1:0][TOKEN_BITS-1:0] tok_row_t;

    // configuration
    logic [RUN_W-1:0]  deg_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [PREDECESSORS-1:0] conn;

    // sequencer
    state_t state_reg, state_next;
    logic   req_take;
    logic   req_ok;

    // latched request
    logic [CMD_W-1:0]  cmd_reg;
    logic [INST_W-1:0] inst_req_reg;
    logic [PRED_W-1:0] pred_reg;
    logic [FIRE_W-1:0] n_reg;
    logic [IW-1:0]     inst_idx;
    logic [IW-1:0]     rd_idx;

    // state memories and their valid bits
    logic [INSTANCES-1:0] tok_vld_reg;
    logic [INSTANCES-1:0] inst_vld_reg;
    logic                 tok_we;
    logic                 inst_we;
    logic [TOK_ROW_W-1:0] tok_rdata;
    logic [INST_ROW_W-1:0] inst_rdata;
    tok_row_t             tok_cur, tok_bump, tok_next;
    inst_row_t            row_cur, row_wr;
    logic [PW-1:0]        pred_idx;
    logic                 slot_ok;
    logic                 tok_all;

    // values worked out in the modify cycle
    logic [FIRE_W:0]   q_sum;
    logic [FIRE_W-1:0] x_q;
    logic [RUN_W-1:0]  x_run;
    logic [COMP_W-1:0] x_comp;
    logic [EV_W-1:0]   x_ev;
    logic              x_lim_one;
    logic              x_events;

    // working registers of the event sequence
    logic [FIRE_W-1:0]   q_reg;
    logic [RUN_W-1:0]    run_reg;
    logic [COMP_W-1:0]   comp_reg;
    logic [EV_W-1:0]     ev_reg;
    logic                lim_one_reg;
    logic [STARTS_W-1:0] starts_reg;
    logic                first_reg;
    logic [STARTS_W-1:0] lim;

    // next event
    logic [EV_W-1:0]     e_ev;
    logic [FIRE_W-1:0]   e_q;
    logic [RUN_W-1:0]    e_run;
    logic [STARTS_W-1:0] e_starts;
    logic                e_last;

    // output register
    logic              evt_valid_reg;
    logic              evt_valid_next;
    logic [EV_W-1:0]   evt_res_reg;
    logic [INST_W-1:0] evt_inst_reg;
    logic [COMP_W-1:0] evt_comp_reg;
    logic [FIRE_W-1:0] evt_q_reg;
    logic              evt_last_reg;
    logic              slot_free;
    logic              load_evt;

    function automatic logic can_start(
        input logic [RUN_W-1:0]    run,
        input logic [RUN_W-1:0]    deg,
        input logic [FIRE_W-1:0]   q,
        input logic [STARTS_W-1:0] starts,
        input logic [STARTS_W-1:0] limit
    );
        return (run < deg) && (q != '0) && (starts < limit);
    endfunction

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg  <= RUN_W'(1);
            mask_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PARALLELISM: deg_reg  <= cfg.data[RUN_W-1:0];
                CFG_PRED_MASK:   mask_reg <= cfg.data[MASK_W-1:0];
                default:         ;
            endcase
        end
    end

    // connected slots; slots past the mask width never connect
    for (genvar p = 0; p < PREDECESSORS; p++)
    begin : g_conn
        if (p < MASK_W)
        begin : g_in
            assign conn[p] = mask_reg[p];
        end
        else
        begin : g_out
            assign conn[p] = 1'b0;
        end
    end

    // request decode
    assign req_take = req.valid && req.ready;
    assign req_ok   = (req.command == CMD_TOKEN || req.command == CMD_DONE ||
                       req.command == CMD_ENQUEUE) &&
                      (32'(req.instance_req) < 32'(INSTANCES));
    assign inst_idx = IW'(inst_req_reg);
    assign rd_idx   = (state_reg == ST_IDLE) ? IW'(req.instance_req) : inst_idx;

    // state memories
    dfs_ram #(
        .WIDTH (TOK_ROW_W),
        .DEPTH (INSTANCES)
    ) u_tok_ram (
        .clk   (clk),
        .we    (tok_we),
        .waddr (inst_idx),
        .wdata (tok_next),
        .raddr (rd_idx),
        .rdata (tok_rdata)
    );

    dfs_ram #(
        .WIDTH (INST_ROW_W),
        .DEPTH (INSTANCES)
    ) u_inst_ram (
        .clk   (clk),
        .we    (inst_we),
        .waddr (inst_idx),
        .wdata (row_wr),
        .raddr (rd_idx),
        .rdata (inst_rdata)
    );

    // token row update: bump the sending slot, consume a set when complete
    assign pred_idx = PW'(pred_reg);
    assign slot_ok  = (cmd_reg == CMD_TOKEN) &&
                      (32'(pred_reg) < 32'(PREDECESSORS)) && conn[pred_idx];

    always_comb
    begin
        tok_all = 1'b1;
        for (int p = 0; p < PREDECESSORS; p++)
        begin
            tok_cur[p]  = tok_vld_reg[inst_idx] ? tok_rdata[p*TOKEN_BITS +: TOKEN_BITS]
                                                : '0;
            tok_bump[p] = (slot_ok && (PW'(p) == pred_idx) && (tok_cur[p] != '1))
                          ? tok_cur[p] + 1'b1 : tok_cur[p];
            if (conn[p] && (tok_bump[p] == '0))
            begin
                tok_all = 1'b0;
            end
        end
        for (int p = 0; p < PREDECESSORS; p++)
        begin
            tok_next[p] = (tok_all && conn[p]) ? tok_bump[p] - 1'b1 : tok_bump[p];
        end
    end

    // instance row update for the request
    assign row_cur = inst_vld_reg[inst_idx] ? inst_row_t'(inst_rdata) : '0;

    always_comb
    begin
        x_q       = row_cur.queued;
        x_run     = row_cur.running;
        x_comp    = row_cur.completed;
        x_ev      = EV_REQUEST;
        x_lim_one = 1'b0;
        x_events  = 1'b0;
        q_sum     = {1'b0, row_cur.queued};
        unique case (cmd_reg)
            CMD_TOKEN:
            begin
                q_sum    = {1'b0, row_cur.queued} + (FIRE_W + 1)'(1);
                x_q      = q_sum[FIRE_W] ? '1 : q_sum[FIRE_W-1:0];
                x_events = slot_ok && tok_all;
            end
            CMD_DONE:
            begin
                x_run     = (row_cur.running != '0) ? row_cur.running - 1'b1
                                                    : row_cur.running;
                x_comp    = row_cur.completed + 1'b1;
                x_ev      = EV_DONE;
                x_lim_one = 1'b1;
                x_events  = 1'b1;
            end
            CMD_ENQUEUE:
            begin
                q_sum    = {1'b0, row_cur.queued} + {1'b0, n_reg};
                x_q      = q_sum[FIRE_W] ? '1 : q_sum[FIRE_W-1:0];
                x_events = 1'b1;
            end
            default:
            begin
                x_events = 1'b0;
            end
        endcase
    end

    // next event: the leading event, then one start per cycle while the output register is free
    assign lim = lim_one_reg ? STARTS_W'(1) : STARTS_W'(MAX_RESULTS - 1);

    always_comb
    begin
        if (first_reg)
        begin
            e_ev     = ev_reg;
            e_q      = q_reg;
            e_run    = run_reg;
            e_starts = starts_reg;
        end
        else
        begin
            e_ev     = EV_START;
            e_q      = q_reg - 1'b1;
            e_run    = run_reg + 1'b1;
            e_starts = starts_reg + 1'b1;
        end
        e_last = !can_start(e_run, deg_reg, e_q, e_starts, lim);
    end

    assign row_wr    = '{queued: e_q, running: e_run, completed: comp_reg};
    assign slot_free = !evt_valid_reg || evt.ready;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take && req_ok)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = x_events ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (slot_free && e_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready = 1'b0;
        tok_we    = 1'b0;
        inst_we   = 1'b0;
        load_evt  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_EXEC:
            begin
                tok_we = slot_ok;
            end
            ST_EMIT:
            begin
                load_evt = slot_free;
                inst_we  = slot_free && e_last;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // control registers
    assign evt_valid_next = load_evt ? 1'b1 : (evt.ready ? 1'b0 : evt_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= 1'b0;
            evt_valid_reg <= 1'b0;
            tok_vld_reg   <= '0;
            inst_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            evt_valid_reg <= evt_valid_next;
            if (state_reg == ST_EXEC)
            begin
                first_reg <= 1'b1;
            end
            else if (load_evt)
            begin
                first_reg <= 1'b0;
            end
            if (tok_we)
            begin
                tok_vld_reg[inst_idx] <= 1'b1;
            end
            if (inst_we)
            begin
                inst_vld_reg[inst_idx] <= 1'b1;
            end
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg      <= req.command;
            inst_req_reg <= req.instance_req;
            pred_reg     <= req.predecessor;
            n_reg        <= req.firing_count;
        end
    end

    // working registers of the event sequence
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            q_reg       <= x_q;
            run_reg     <= x_run;
            comp_reg    <= x_comp;
            ev_reg      <= x_ev;
            lim_one_reg <= x_lim_one;
            starts_reg  <= '0;
        end
        else if (load_evt)
        begin
            q_reg      <= e_q;
            run_reg    <= e_run;
            starts_reg <= e_starts;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load_evt)
        begin
            evt_res_reg  <= e_ev;
            evt_inst_reg <= inst_req_reg;
            evt_comp_reg <= comp_reg;
            evt_q_reg    <= e_q;
            evt_last_reg <= e_last;
        end
    end

    assign evt.valid           = evt_valid_reg;
    assign evt.event_res       = evt_res_reg;
    assign evt.event_instance  = evt_inst_reg;
    assign evt.completed_total = evt_comp_reg;
    assign evt.queued_left     = evt_q_reg;
    assign evt.last            = evt_last_reg;

    // a start never pushes the running count past the degree
    a_start_within_degree: assert property (@(posedge clk) disable iff (!rst_n)
        load_evt && !first_reg |-> e_run <= deg_reg)
        else $error("start exceeds parallelism degree");

    // a start always takes a queued firing
    a_start_has_firing: assert property (@(posedge clk) disable iff (!rst_n)
        load_evt && !first_reg |-> q_reg != '0)
        else $error("start with empty queue");

    // a completion starts at most one execution
    a_done_one_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && lim_one_reg && !first_reg |-> starts_reg == '0)
        else $error("completion started more than one execution");

    // the last event of a request hands control back
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_evt && e_last |=> state_reg == ST_IDLE)
        else $error("sequencer not idle after last event");

    // no request is taken while events are being produced
    a_no_take_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !req.ready)
        else $error("request taken during event sequence");

endmodule

`default_nettype wire
